FILE: hdl/tlca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_pkg
// Types and constants shared by the tree ancestor engine.
// ----------------------------------------------------------------------------
package tlca_pkg;

	localparam int VW      = 10;
	localparam int CW      = 11;
	localparam int MAX_V   = 1024;
	localparam int EDGE_CAP = MAX_V - 1;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_BUILD = 2'd1,
		OP_ANC   = 2'd2,
		OP_PAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_BUILT = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NO_PARENT = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]    operation;
		logic [VW-1:0] endpoint_a;
		logic [VW-1:0] endpoint_b;
	} in_t;

	typedef struct packed {
		logic [VW-1:0] vertex;
		logic [1:0]    status;
	} out_t;

	typedef struct packed {
		op_t           op;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		logic          in_range;
	} cmd_t;

	typedef struct packed {
		logic [VW-1:0] v;
		logic [VW-1:0] c;
	} frame_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ADD, S_BLD, S_CLR, S_INIT, S_SRD, S_SEV, S_SRC,
		S_POP, S_POPW, S_QRA, S_QCA, S_QCB, S_CLB, S_CUP
	} eng_state_t;

endpackage
`default_nettype wire

FILE: hdl/tlca_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_front
// Accepts transactions, decodes and range checks them, queues them.
// ----------------------------------------------------------------------------
module tlca_front import tlca_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire in_t           req,
	input  wire logic [CW-1:0] n_eff,
	input  wire logic          pop,
	output logic               busy,
	output logic               q_valid,
	output cmd_t               q_cmd
);

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cmd_in;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start & ~busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = ent_q[rp_q];

	always_comb begin
		cmd_in.op       = op_t'(req.operation);
		cmd_in.a        = req.endpoint_a;
		cmd_in.b        = req.endpoint_b;
		cmd_in.in_range = ({1'b0, req.endpoint_a} < n_eff) && ({1'b0, req.endpoint_b} < n_eff);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

FILE: hdl/tlca_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_engine
// Edge store, depth-first walk building parent/height tables, and query unit.
// ----------------------------------------------------------------------------
module tlca_engine import tlca_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire cmd_t          q_cmd,
	input  wire logic [VW-1:0] root,
	input  wire logic [CW-1:0] n_eff,
	output logic               pop,
	output logic               done,
	output out_t               result
);

	logic [2*VW-1:0] edge_mem   [EDGE_CAP];
	logic            reach_mem  [MAX_V];
	logic [VW-1:0]   height_mem [MAX_V];
	logic [VW-1:0]   parent_mem [MAX_V];
	frame_t          stack_mem  [MAX_V];

	eng_state_t    st_q, st_d;
	cmd_t          cmd_q;
	logic [VW-1:0] total_q, broot_q, topv_q, cur_q, h_q, nb_q, clr_q;
	logic [VW-1:0] x_q, y_q, hx_q, hy_q;
	logic [CW-1:0] sp_q, spm1, spm2;
	logic          ready_q, done_q;
	out_t          res_q;

	logic [2*VW-1:0] edge_rd;
	logic            reach_rd;
	logic [VW-1:0]   height_rd, par_rd0, par_rd1;
	frame_t          stack_rd;

	logic [VW-1:0] reach_ra, height_ra, par_ra0;
	logic          fin;
	out_t          fin_res;
	logic [VW-1:0] ea, eb, nb;
	logic          hit;

	assign done   = done_q;
	assign result = res_q;
	assign spm1   = sp_q - CW'(1);
	assign spm2   = sp_q - CW'(2);
	assign ea     = edge_rd[VW-1:0];
	assign eb     = edge_rd[2*VW-1:VW];

	always_comb begin
		hit = 1'b0;
		nb  = ea;
		if (({1'b0, ea} < n_eff) && ({1'b0, eb} < n_eff)) begin
			if (ea == topv_q) begin
				hit = 1'b1;
				nb  = eb;
			end else if (eb == topv_q) begin
				hit = 1'b1;
				nb  = ea;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.op)
						OP_ADD:   st_d = S_ADD;
						OP_BUILD: st_d = S_BLD;
						default:  st_d = S_QRA;
					endcase
				end
			end
			S_ADD:  st_d = S_IDLE;
			S_BLD:  st_d = ({1'b0, root} < n_eff) ? S_CLR : S_IDLE;
			S_CLR:  st_d = (clr_q == VW'(MAX_V - 1)) ? S_INIT : S_CLR;
			S_INIT: st_d = S_SRD;
			S_SRD:  st_d = (cur_q >= total_q) ? S_POP : S_SEV;
			S_SEV:  st_d = hit ? S_SRC : S_SRD;
			S_SRC:  st_d = S_SRD;
			S_POP:  st_d = (sp_q == CW'(1)) ? S_IDLE : S_POPW;
			S_POPW: st_d = S_SRD;
			S_QRA:  st_d = ready_q ? S_QCA : S_IDLE;
			S_QCA:  st_d = (reach_rd && cmd_q.op == OP_ANC) ? S_QCB : S_IDLE;
			S_QCB:  st_d = reach_rd ? S_CLB : S_IDLE;
			S_CLB:  st_d = (x_q == y_q) ? S_IDLE : S_CUP;
			S_CUP:  st_d = S_CLB;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		fin       = 1'b0;
		fin_res   = '0;
		reach_ra  = cmd_q.a;
		height_ra = cmd_q.a;
		par_ra0   = cmd_q.a;
		unique case (st_q)
			S_IDLE: pop = q_valid;
			S_ADD: begin
				fin = 1'b1;
				if (!cmd_q.in_range || total_q == VW'(EDGE_CAP)) begin
					fin_res.status = ST_RANGE;
				end
			end
			S_BLD: begin
				if ({1'b0, root} >= n_eff) begin
					fin            = 1'b1;
					fin_res.status = ST_RANGE;
				end
			end
			S_SEV: reach_ra = nb;
			S_POP: fin = (sp_q == CW'(1));
			S_QRA: begin
				if (!ready_q) begin
					fin            = 1'b1;
					fin_res.status = ST_NOT_BUILT;
				end
			end
			S_QCA: begin
				reach_ra  = cmd_q.b;
				height_ra = cmd_q.b;
				if (!reach_rd) begin
					fin            = 1'b1;
					fin_res.status = ST_RANGE;
				end else if (cmd_q.op == OP_PAR) begin
					fin = 1'b1;
					if (cmd_q.a == broot_q) begin
						fin_res.status = ST_NO_PARENT;
					end else begin
						fin_res.vertex = par_rd0;
					end
				end
			end
			S_QCB: begin
				if (!reach_rd) begin
					fin            = 1'b1;
					fin_res.status = ST_RANGE;
				end
			end
			S_CLB: begin
				par_ra0 = x_q;
				if (x_q == y_q) begin
					fin            = 1'b1;
					fin_res.vertex = x_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		edge_rd   <= edge_mem[cur_q];
		reach_rd  <= reach_mem[reach_ra];
		height_rd <= height_mem[height_ra];
		par_rd0   <= parent_mem[par_ra0];
		par_rd1   <= parent_mem[y_q];
		stack_rd  <= stack_mem[spm2[VW-1:0]];
		if (st_q == S_ADD && cmd_q.in_range && total_q != VW'(EDGE_CAP)) begin
			edge_mem[total_q] <= {cmd_q.b, cmd_q.a};
		end
		if (st_q == S_CLR) begin
			reach_mem[clr_q] <= 1'b0;
		end else if (st_q == S_INIT) begin
			reach_mem[root] <= 1'b1;
		end else if (st_q == S_SRC && !reach_rd) begin
			reach_mem[nb_q] <= 1'b1;
		end
		if (st_q == S_INIT) begin
			height_mem[root] <= '0;
			parent_mem[root] <= root;
		end else if (st_q == S_SRC && !reach_rd) begin
			height_mem[nb_q] <= h_q + VW'(1);
			parent_mem[nb_q] <= topv_q;
			stack_mem[spm1[VW-1:0]] <= '{v: topv_q, c: cur_q + VW'(1)};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		unique case (st_q)
			S_BLD: clr_q <= '0;
			S_CLR: clr_q <= clr_q + VW'(1);
			S_INIT: begin
				topv_q <= root;
				cur_q  <= '0;
				h_q    <= '0;
				sp_q   <= CW'(1);
			end
			S_SEV: begin
				if (hit) begin
					nb_q <= nb;
				end else begin
					cur_q <= cur_q + VW'(1);
				end
			end
			S_SRC: begin
				if (reach_rd) begin
					cur_q <= cur_q + VW'(1);
				end else begin
					topv_q <= nb_q;
					cur_q  <= '0;
					h_q    <= h_q + VW'(1);
					sp_q   <= sp_q + CW'(1);
				end
			end
			S_POPW: begin
				topv_q <= stack_rd.v;
				cur_q  <= stack_rd.c;
				h_q    <= h_q - VW'(1);
				sp_q   <= spm1;
			end
			S_QCA: begin
				x_q  <= cmd_q.a;
				hx_q <= height_rd;
			end
			S_QCB: begin
				y_q  <= cmd_q.b;
				hy_q <= height_rd;
			end
			S_CUP: begin
				if (hx_q >= hy_q) begin
					x_q  <= par_rd0;
					hx_q <= hx_q - VW'(1);
				end
				if (hy_q >= hx_q) begin
					y_q  <= par_rd1;
					hy_q <= hy_q - VW'(1);
				end
			end
			default: begin
			end
		endcase
		if (fin) begin
			res_q <= fin_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			total_q <= '0;
			ready_q <= 1'b0;
			broot_q <= '0;
			done_q  <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= fin;
			if (st_q == S_ADD && cmd_q.in_range && total_q != VW'(EDGE_CAP)) begin
				total_q <= total_q + VW'(1);
				ready_q <= 1'b0;
			end
			if (st_q == S_BLD) begin
				ready_q <= 1'b0;
			end
			if (st_q == S_POP && sp_q == CW'(1)) begin
				ready_q <= 1'b1;
				broot_q <= root;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/tree_lowest_common_ancestor.sv
// Ancestor query: the climb steps are bounded by the tree height.
// Build: a sweep clears all 1024 reached flags, then each vertex of the walk scans the
// edge store, with an extra step on an incident edge; the shared edge store port sets this.
// A 2-entry queue takes new transactions while the engine works, until it fills; done pulses once.
// Reset clears control and the edge count; tables need a build.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tree_lowest_common_ancestor
// Tree loader with depth-first build and ancestor/parent queries.
// ----------------------------------------------------------------------------
module tree_lowest_common_ancestor import tlca_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire in_t         req,
	output logic             busy,
	output logic             done,
	output out_t             result,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [10:0] cfg_data
);

	logic [VW-1:0] root_q;
	logic [CW-1:0] vcount_q, n_eff;
	logic          q_valid, pop;
	cmd_t          q_cmd;

	assign n_eff = (vcount_q > CW'(MAX_V)) ? CW'(MAX_V) : vcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q   <= '0;
			vcount_q <= CW'(MAX_V);
		end else if (cfg_we) begin
			if (cfg_idx) begin
				vcount_q <= cfg_data;
			end else begin
				root_q <= cfg_data[VW-1:0];
			end
		end
	end

	tlca_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.n_eff   (n_eff),
		.pop     (pop),
		.busy    (busy),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	tlca_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.root    (root_q),
		.n_eff   (n_eff),
		.pop     (pop),
		.done    (done),
		.result  (result)
	);

endmodule
`default_nettype wire

FILE: sim/tree_lowest_common_ancestor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_lowest_common_ancestor_tb
// Loads edge sets, builds from varied roots and vertex counts, then issues
// ancestor and parent queries. Each result is checked against a tree walk
// done in the bench, with random sender idling and a full edge store at the end.
// ----------------------------------------------------------------------------
module tree_lowest_common_ancestor_tb;
	import tlca_pkg::*;

	localparam bit REG_ROOT  = 1'b0;
	localparam bit REG_COUNT = 1'b1;

	class lca_scoreboard;
		int unsigned root_cfg, count_cfg;
		int ea[$], eb[$];
		bit ready;
		int built_root;
		bit reached[MAX_V];
		int parent[MAX_V];
		int depth[MAX_V];
		int adj[MAX_V][$];
		out_t pending[$];
		int fails;

		function new();
			root_cfg = 0;
			count_cfg = MAX_V;
			ready = 0;
			fails = 0;
		endfunction

		function void set_reg(bit idx, int unsigned val);
			if (idx == REG_ROOT) root_cfg = val & 10'h3ff;
			else count_cfg = val & 11'h7ff;
		endfunction

		function int live();
			return (count_cfg > MAX_V) ? MAX_V : count_cfg;
		endfunction

		function bit walk_tree();
			int n, sp, v, w;
			int stk_v[MAX_V];
			int stk_c[MAX_V];
			n = live();
			ready = 0;
			if (root_cfg >= n) return 0;
			for (int i = 0; i < MAX_V; i++) begin
				adj[i].delete();
				reached[i] = 0;
			end
			foreach (ea[e])
				if (ea[e] < n && eb[e] < n) begin
					adj[ea[e]] = {adj[ea[e]], eb[e]};
					adj[eb[e]] = {adj[eb[e]], ea[e]};
				end
			reached[root_cfg] = 1;
			depth[root_cfg] = 0;
			parent[root_cfg] = -1;
			stk_v[0] = root_cfg;
			stk_c[0] = 0;
			sp = 1;
			while (sp > 0) begin
				v = stk_v[sp-1];
				while (stk_c[sp-1] < adj[v].size() && reached[adj[v][stk_c[sp-1]]])
					stk_c[sp-1]++;
				if (stk_c[sp-1] < adj[v].size()) begin
					w = adj[v][stk_c[sp-1]];
					stk_c[sp-1]++;
					reached[w] = 1;
					depth[w] = depth[v] + 1;
					parent[w] = v;
					stk_v[sp] = w;
					stk_c[sp] = 0;
					sp++;
				end else begin
					sp--;
				end
			end
			built_root = root_cfg;
			ready = 1;
			return 1;
		endfunction

		function void note(in_t x);
			out_t r;
			int a, b;
			a = x.endpoint_a;
			b = x.endpoint_b;
			r.vertex = '0;
			r.status = ST_OK;
			case (op_t'(x.operation))
				OP_ADD: begin
					if (a >= live() || b >= live() || ea.size() >= EDGE_CAP) begin
						r.status = ST_RANGE;
					end else begin
						ea = {ea, a};
						eb = {eb, b};
						ready = 0;
					end
				end
				OP_BUILD: r.status = walk_tree() ? ST_OK : ST_RANGE;
				default: begin
					if (!ready) r.status = ST_NOT_BUILT;
					else if (!reached[a] || (x.operation == OP_ANC && !reached[b]))
						r.status = ST_RANGE;
					else if (x.operation == OP_ANC) begin
						while (depth[a] > depth[b]) a = parent[a];
						while (depth[b] > depth[a]) b = parent[b];
						while (a != b) begin
							a = parent[a];
							b = parent[b];
						end
						r.vertex = VW'(a);
					end else if (a == built_root) r.status = ST_NO_PARENT;
					else r.vertex = VW'(parent[a]);
				end
			endcase
			pending = {pending, r};
		endfunction

		function void check(out_t got);
			out_t e;
			if (pending.size() == 0) begin
				$error("unexpected result vertex=%0d status=%0d", got.vertex, got.status);
				fails++;
				return;
			end
			e = pending.pop_front();
			if (got.vertex !== e.vertex) begin
				$error("vertex: expected %0d, actual %0d", e.vertex, got.vertex);
				fails++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status);
				fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	in_t         req;
	logic        busy;
	logic        done;
	out_t        result;
	logic        cfg_we;
	logic        cfg_idx;
	logic [10:0] cfg_data;

	lca_scoreboard sb;
	int idle_pct;
	int sent;

	tree_lowest_common_ancestor dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000_000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && done) sb.check(result);

	task automatic send(int unsigned op, int unsigned a, int unsigned b);
		in_t x;
		x.operation = 2'(op);
		x.endpoint_a = 10'(a);
		x.endpoint_b = 10'(b);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= x;
		do @(posedge clk); while (busy);
		sb.note(x);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(bit idx, int unsigned val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= 11'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic tree_round();
		int n, k, off, u, v, q;
		if ($urandom_range(19) == 0) n = MAX_V;
		else if ($urandom_range(19) == 0) n = 1;
		else n = $urandom_range(2, 40);
		write_reg(REG_COUNT, n);
		write_reg(REG_ROOT, ($urandom_range(9) == 0) ? $urandom_range(1023)
			: $urandom_range(n - 1));
		if ($urandom_range(1)) drain();
		k = (n == MAX_V) ? $urandom_range(1, 30) : $urandom_range(0, n - 1);
		off = $urandom_range(n - 1);
		for (int i = 1; i <= k; i++) begin
			if ($urandom_range(9) == 0) begin
				send(OP_ADD, $urandom_range(1023), $urandom_range(1023));
			end else begin
				v = (i + off) % n;
				u = ($urandom_range(i - 1) + off) % n;
				if ($urandom_range(1)) send(OP_ADD, v, u);
				else send(OP_ADD, u, v);
			end
		end
		if ($urandom_range(7) == 0) send(OP_ANC, $urandom_range(n - 1), 0);
		send(OP_BUILD, $urandom_range(1023), $urandom_range(1023));
		q = $urandom_range(10, 30);
		for (int i = 0; i < q; i++) begin
			case ($urandom_range(19))
				0: send(OP_ADD, $urandom_range(1023), $urandom_range(1023));
				1: send($urandom_range(2, 3), $urandom_range(1023), $urandom_range(1023));
				default: send($urandom_range(2, 3), $urandom_range(n - 1),
					$urandom_range(n - 1));
			endcase
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_idx = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_ANC, 0, 0);
		send(OP_PAR, 1023, 1023);
		send(OP_BUILD, 0, 0);
		send(OP_PAR, 0, 0);
		send(OP_ANC, 0, 1023);
		write_reg(REG_COUNT, 8);
		write_reg(REG_ROOT, 0);
		send(OP_ADD, 0, 1);
		send(OP_ADD, 1, 2);
		send(OP_ADD, 1, 3);
		send(OP_ADD, 0, 9);
		send(OP_ADD, 1023, 0);
		send(OP_ADD, 2, 2);
		send(OP_ADD, 3, 1);
		send(OP_ANC, 2, 3);
		send(OP_BUILD, 0, 0);
		send(OP_ANC, 2, 3);
		send(OP_PAR, 2, 0);
		send(OP_ANC, 7, 2);
		send(OP_ADD, 4, 5);
		send(OP_PAR, 1, 0);
		write_reg(REG_ROOT, 9);
		send(OP_BUILD, 0, 0);
		send(OP_PAR, 1, 0);
		write_reg(REG_COUNT, 1024);
		write_reg(REG_ROOT, 1023);
		send(OP_BUILD, 1023, 1023);
		send(OP_PAR, 1023, 0);
		send(OP_ANC, 1023, 1023);

		while (sent < 1200) begin
			case ((sent / 150) % 4)
				0: idle_pct = 0;
				1: idle_pct = 88;
				2: idle_pct = 0;
				default: idle_pct = 29;
			endcase
			tree_round();
			if ($urandom_range(9) == 0) drain();
		end

		// fill the edge store to its limit
		idle_pct = 0;
		write_reg(REG_COUNT, 12);
		write_reg(REG_ROOT, 0);
		while (sb.ea.size() < EDGE_CAP)
			send(OP_ADD, $urandom_range(11), $urandom_range(11));
		send(OP_ADD, 0, 1);
		send(OP_ADD, 11, 11);
		send(OP_BUILD, 0, 0);
		for (int i = 0; i < 12; i++)
			send($urandom_range(2, 3), $urandom_range(11), $urandom_range(11));

		drain();
		repeat (20) @(posedge clk);
		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
